>>> rtl/core/trt_pkg.sv
package trt_pkg;

	localparam int CHANNELS      = 64;
	localparam int FRACTION_BITS = 16;

	localparam int CHAN_W    = 6;
	localparam int PRICE_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int SLOT_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FACT_W    = ((FRACTION_BITS > FRAC_W) ? FRACTION_BITS : FRAC_W) + 2;
	localparam int PROD_W    = PRICE_W + FACT_W;
	localparam int GPROD_W   = PRICE_W + FRAC_W;
	localparam int SUM_W     = GPROD_W + 1;
	localparam int RED_W     = CHAN_W + 11;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [PRICE_W-1:0] price_t;
	typedef logic [FRAC_W-1:0]  frac_t;
	typedef logic [FACT_W-1:0]  fact_t;
	typedef logic [PROD_W-1:0]  prod_t;
	typedef logic [GPROD_W-1:0] gprod_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [RED_W-1:0]   red_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START    = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_APPROACH = cfg_idx_t'(1);

	localparam frac_t START_RESET    = frac_t'(2621);
	localparam frac_t APPROACH_RESET = frac_t'(131);

	localparam fact_t FRAC_ONE = fact_t'(1) << FRACTION_BITS;

	typedef struct packed {
		logic  en;
		slot_t slot;
	} rd_req_t;

	typedef struct packed {
		logic   en;
		slot_t  slot;
		price_t level;
		logic   sold;
	} wr_req_t;

	typedef struct packed {
		price_t level;
		logic   sold;
		logic   seen;
	} entry_t;

	typedef struct packed {
		chan_t  channel;
		price_t level;
		logic   sold;
	} result_t;

	function automatic slot_t slot_of(input chan_t ch);
		red_t r;
		r = red_t'(ch);
		for (int i = CHAN_W - 1; i >= 0; i--) begin
			if (r >= (red_t'(CHANNELS) << i)) begin
				r = r - (red_t'(CHANNELS) << i);
			end
		end
		return slot_t'(r);
	endfunction

endpackage

>>> rtl/core/trt_store.sv
module trt_store (
	input  logic              clk,
	input  logic              arst_n,
	input  trt_pkg::rd_req_t  rd,
	input  trt_pkg::wr_req_t  wr,
	input  trt_pkg::slot_t    look_slot,
	output trt_pkg::entry_t   entry
);

	logic [trt_pkg::PRICE_W:0] mem [trt_pkg::CHANNELS];
	logic [trt_pkg::PRICE_W:0] rdata_q;
	logic [trt_pkg::CHANNELS-1:0] seen_q;
	logic                      wb_valid_q;
	trt_pkg::slot_t            wb_slot_q;
	logic [trt_pkg::PRICE_W:0] wb_data_q;
	logic                      live_hit;
	logic                      wb_hit;
	logic [trt_pkg::PRICE_W:0] data;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.slot] <= {wr.sold, wr.level};
		end
		if (rd.en) begin
			rdata_q <= mem[rd.slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			wb_valid_q <= 1'b0;
		end else if (wr.en) begin
			seen_q[wr.slot] <= 1'b1;
			wb_valid_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			wb_slot_q <= wr.slot;
			wb_data_q <= {wr.sold, wr.level};
		end
	end

	// forward: live write, then last write, then memory
	always_comb begin
		live_hit = wr.en && (wr.slot == look_slot);
		wb_hit   = wb_valid_q && (wb_slot_q == look_slot);
		if (live_hit) begin
			data = {wr.sold, wr.level};
		end else if (wb_hit) begin
			data = wb_data_q;
		end else begin
			data = rdata_q;
		end
		entry.level = data[trt_pkg::PRICE_W-1:0];
		entry.sold  = data[trt_pkg::PRICE_W];
		entry.seen  = seen_q[look_slot] | live_hit;
	end

endmodule

>>> rtl/core/trt_pipe.sv
module trt_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  trt_pkg::chan_t    channel,
	input  trt_pkg::price_t   price,
	input  trt_pkg::frac_t    start_q,
	input  trt_pkg::frac_t    approach_q,
	input  logic              out_free,
	input  trt_pkg::entry_t   entry,
	output logic              can_take,
	output trt_pkg::rd_req_t  rd,
	output trt_pkg::slot_t    look_slot,
	output trt_pkg::wr_req_t  wr,
	output trt_pkg::result_t  res
);

	logic            valid_s1;
	trt_pkg::chan_t  channel_s1;
	trt_pkg::slot_t  slot_s1;
	trt_pkg::price_t price_s1;

	logic            valid_s2;
	trt_pkg::chan_t  channel_s2;
	trt_pkg::slot_t  slot_s2;
	trt_pkg::price_t price_s2;
	trt_pkg::price_t below_s2;
	trt_pkg::price_t above_s2;
	trt_pkg::price_t level_s2;
	logic            sold_s2;
	logic            seen_s2;

	logic            adv_s1;
	logic            adv_s2;
	logic            s2_open;

	trt_pkg::fact_t  below_factor;
	trt_pkg::fact_t  above_factor;
	trt_pkg::prod_t  below_prod;
	trt_pkg::prod_t  above_prod;
	trt_pkg::prod_t  above_sh;
	trt_pkg::price_t above_level;

	trt_pkg::price_t cur_level;
	logic            cur_sold;
	trt_pkg::price_t gap;
	trt_pkg::gprod_t gprod;
	trt_pkg::gprod_t delta;
	trt_pkg::sum_t   sum;
	trt_pkg::price_t new_level;
	logic            new_sold;

	always_comb begin
		adv_s2   = valid_s2 && out_free;
		s2_open  = !valid_s2 || out_free;
		adv_s1   = valid_s1 && s2_open;
		can_take = !valid_s1 || s2_open;
		rd.en    = take;
		rd.slot  = trt_pkg::slot_of(channel);
		look_slot = slot_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			channel_s1 <= channel;
			slot_s1    <= rd.slot;
			price_s1   <= price;
		end
	end

	// offset products on the incoming price
	always_comb begin
		if (trt_pkg::fact_t'(start_q) >= trt_pkg::FRAC_ONE) begin
			below_factor = '0;
		end else begin
			below_factor = trt_pkg::FRAC_ONE - trt_pkg::fact_t'(start_q);
		end
		above_factor = trt_pkg::FRAC_ONE + trt_pkg::fact_t'(start_q);
		below_prod   = trt_pkg::prod_t'(price_s1) * trt_pkg::prod_t'(below_factor);
		above_prod   = trt_pkg::prod_t'(price_s1) * trt_pkg::prod_t'(above_factor);
		above_sh     = above_prod >> trt_pkg::FRACTION_BITS;
		if (|above_sh[trt_pkg::PROD_W-1:trt_pkg::PRICE_W]) begin
			above_level = '1;
		end else begin
			above_level = above_sh[trt_pkg::PRICE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			channel_s2 <= channel_s1;
			slot_s2    <= slot_s1;
			price_s2   <= price_s1;
			below_s2   <= trt_pkg::price_t'(below_prod >> trt_pkg::FRACTION_BITS);
			above_s2   <= above_level;
			level_s2   <= entry.level;
			sold_s2    <= entry.sold;
			seen_s2    <= entry.seen;
		end
	end

	// step the channel: flip on crossing, else close part of the gap
	always_comb begin
		cur_level = seen_s2 ? level_s2 : below_s2;
		cur_sold  = seen_s2 && sold_s2;
		gap       = cur_sold ? (cur_level - price_s2) : (price_s2 - cur_level);
		gprod     = trt_pkg::gprod_t'(gap) * trt_pkg::gprod_t'(approach_q);
		delta     = gprod >> trt_pkg::FRACTION_BITS;
		sum       = trt_pkg::sum_t'(cur_level) + trt_pkg::sum_t'(delta);
		if (cur_sold) begin
			if (price_s2 > cur_level) begin
				new_sold  = 1'b0;
				new_level = below_s2;
			end else begin
				new_sold = 1'b1;
				if (delta > trt_pkg::gprod_t'(cur_level)) begin
					new_level = '0;
				end else begin
					new_level = cur_level - delta[trt_pkg::PRICE_W-1:0];
				end
			end
		end else begin
			if (price_s2 < cur_level) begin
				new_sold  = 1'b1;
				new_level = above_s2;
			end else begin
				new_sold = 1'b0;
				if (|sum[trt_pkg::SUM_W-1:trt_pkg::PRICE_W]) begin
					new_level = '1;
				end else begin
					new_level = sum[trt_pkg::PRICE_W-1:0];
				end
			end
		end
		wr.en       = adv_s2;
		wr.slot     = slot_s2;
		wr.level    = new_level;
		wr.sold     = new_sold;
		res.channel = channel_s2;
		res.level   = new_level;
		res.sold    = new_sold;
	end

endmodule

>>> rtl/core/trailing_reference_tracker_top.sv
// An accepted item is read and offset multiplied, then updated, then registered for result_valid.
// Throughput: one item per cycle for any channel mix unless result_stall holds the output;
// a repeated channel is served from the write port and the last-write register, not the memory.
// Reset: clears pipeline valids, seen flags and the result valid flag, and loads
// the default fractions; the reference memory is not cleared.
module trailing_reference_tracker_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  trt_pkg::chan_t           channel,
	input  trt_pkg::price_t          price,
	output logic                     result_valid,
	input  logic                     result_stall,
	output trt_pkg::chan_t           channel_out,
	output trt_pkg::price_t          reference,
	output logic                     sold,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  trt_pkg::cfg_idx_t        cfg_index,
	input  trt_pkg::frac_t           cfg_data
);

	trt_pkg::frac_t   start_q;
	trt_pkg::frac_t   approach_q;
	logic             take;
	logic             can_take;
	logic             out_free;
	trt_pkg::rd_req_t rd;
	trt_pkg::wr_req_t wr;
	trt_pkg::slot_t   look_slot;
	trt_pkg::entry_t  entry;
	trt_pkg::result_t res;
	logic             result_valid_q;
	trt_pkg::result_t result_q;

	assign cfg_ready    = 1'b1;
	assign out_free     = !result_valid_q || !result_stall;
	assign sample_stall = !can_take;
	assign take         = sample_valid && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= trt_pkg::START_RESET;
			approach_q <= trt_pkg::APPROACH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				trt_pkg::CFG_START: begin
					start_q <= cfg_data;
				end
				trt_pkg::CFG_APPROACH: begin
					approach_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	trt_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.wr        (wr),
		.look_slot (look_slot),
		.entry     (entry)
	);

	trt_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.channel    (channel),
		.price      (price),
		.start_q    (start_q),
		.approach_q (approach_q),
		.out_free   (out_free),
		.entry      (entry),
		.can_take   (can_take),
		.rd         (rd),
		.look_slot  (look_slot),
		.wr         (wr),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (wr.en) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign channel_out  = result_q.channel;
	assign reference    = result_q.level;
	assign sold         = result_q.sold;

endmodule

>>> rtl/core/trt_checker.sv
module trt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input logic              result_valid,
	input logic              result_stall,
	input trt_pkg::chan_t    channel_out,
	input trt_pkg::price_t   reference,
	input logic              sold,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	logic [2:0] pending_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = sample_valid && !sample_stall;
	assign out_take = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b00, in_take} - {2'b00, out_take};
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 3'd0)
		else $error("result without an outstanding item");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more items in flight than pipeline slots");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> !sample_stall)
		else $error("empty block stalls input");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(reference) && $stable(sold) && $stable(channel_out))
		else $error("stalled result changed");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind trailing_reference_tracker_top trt_checker u_chk (.*);

>>> dv/trailing_reference_tracker_top_tb.sv
`timescale 1ns / 1ps

module trailing_reference_tracker_top_tb;

	localparam int ITEMS_PER_PHASE = 300;
	localparam int PHASES          = 6;
	localparam int PRESSURE_ITEMS  = 60;
	localparam int LONG_HOLD       = 400;
	localparam int LIMIT           = 500000;
	localparam logic [63:0] UNIT      = 64'd1 << trt_pkg::FRACTION_BITS;
	localparam logic [63:0] LEVEL_MAX = 64'hFFFF_FFFF;
	localparam trt_pkg::cfg_idx_t CFG_SPARE_LO = trt_pkg::cfg_idx_t'(2);
	localparam trt_pkg::cfg_idx_t CFG_SPARE_HI = trt_pkg::cfg_idx_t'(3);

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	trt_pkg::chan_t    channel      = '0;
	trt_pkg::price_t   price        = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	trt_pkg::chan_t    channel_out;
	trt_pkg::price_t   reference;
	logic              sold;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	trt_pkg::cfg_idx_t cfg_index    = trt_pkg::CFG_START;
	trt_pkg::frac_t    cfg_data     = '0;

	trt_pkg::frac_t  start_frac    = trt_pkg::START_RESET;
	trt_pkg::frac_t  approach_frac = trt_pkg::APPROACH_RESET;
	trt_pkg::price_t ref_level [trt_pkg::CHANNELS];
	logic            sold_flag [trt_pkg::CHANNELS] = '{default: 1'b0};
	logic            seen_flag [trt_pkg::CHANNELS] = '{default: 1'b0};

	trt_pkg::result_t pending_results [$];
	trt_pkg::result_t oldest;

	int errors         = 0;
	int samples_sent   = 0;
	int results_seen   = 0;
	int first_samples  = 0;
	int flips          = 0;
	int input_stalls   = 0;
	int reg_writes     = 0;
	int cycles         = 0;
	bit tx_idle        = 1'b0;
	bit rx_idle        = 1'b0;
	bit hold_results   = 1'b0;

	trailing_reference_tracker_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.channel      (channel),
		.price        (price),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.channel_out  (channel_out),
		.reference    (reference),
		.sold         (sold),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] below_level(input trt_pkg::price_t p);
		logic [63:0] factor;
		factor = (64'(start_frac) >= UNIT) ? 64'd0 : UNIT - 64'(start_frac);
		return (64'(p) * factor) >> trt_pkg::FRACTION_BITS;
	endfunction

	function automatic logic [63:0] above_level(input trt_pkg::price_t p);
		logic [63:0] v;
		v = (64'(p) * (UNIT + 64'(start_frac))) >> trt_pkg::FRACTION_BITS;
		return (v > LEVEL_MAX) ? LEVEL_MAX : v;
	endfunction

	function automatic trt_pkg::result_t track_sample(input trt_pkg::chan_t ch,
			input trt_pkg::price_t p);
		int               s;
		logic [63:0]      lvl;
		logic [63:0]      step;
		logic             was_sold;
		logic             now_sold;
		trt_pkg::result_t r;
		s = int'(ch) % trt_pkg::CHANNELS;
		if (!seen_flag[s]) begin
			seen_flag[s] = 1'b1;
			first_samples++;
			lvl = below_level(p);
			was_sold = 1'b0;
		end else begin
			lvl = 64'(ref_level[s]);
			was_sold = sold_flag[s];
		end
		now_sold = was_sold;
		if (was_sold) begin
			if (64'(p) > lvl) begin
				now_sold = 1'b0;
				lvl = below_level(p);
			end else begin
				step = ((lvl - 64'(p)) * 64'(approach_frac)) >> trt_pkg::FRACTION_BITS;
				lvl = (step > lvl) ? 64'd0 : lvl - step;
			end
		end else begin
			if (64'(p) < lvl) begin
				now_sold = 1'b1;
				lvl = above_level(p);
			end else begin
				step = ((64'(p) - lvl) * 64'(approach_frac)) >> trt_pkg::FRACTION_BITS;
				lvl = (lvl + step > LEVEL_MAX) ? LEVEL_MAX : lvl + step;
			end
		end
		if (now_sold != was_sold) flips++;
		ref_level[s] = trt_pkg::price_t'(lvl);
		sold_flag[s] = now_sold;
		r.channel = ch;
		r.level   = trt_pkg::price_t'(lvl);
		r.sold    = now_sold;
		return r;
	endfunction

	task automatic send_sample(input trt_pkg::chan_t ch, input trt_pkg::price_t p);
		int gap;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		channel      <= ch;
		price        <= p;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		pending_results.push_back(track_sample(ch, p));
		samples_sent++;
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input trt_pkg::cfg_idx_t idx, input trt_pkg::frac_t val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			trt_pkg::CFG_START: begin
				start_frac = val;
			end
			trt_pkg::CFG_APPROACH: begin
				approach_frac = val;
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		errors++;
		$display("%0t: %s expected %h actual %h", $time, what, want, got);
	endtask

	// advance stall per result; hold long when asked so the block fills up
	initial begin
		int n;
		forever begin
			if (hold_results) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
			end
			n = rx_idle ? $urandom_range(0, 19) : 0;
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && sample_stall) input_stalls++;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item expected none actual ch %0d ref %h sold %0d",
					$time, channel_out, reference, sold);
			end else begin
				oldest = pending_results.pop_front();
				if (channel_out !== oldest.channel)
					report_mismatch("channel_out", 32'(oldest.channel), 32'(channel_out));
				if (reference !== oldest.level)
					report_mismatch("reference", oldest.level, reference);
				if (sold !== oldest.sold)
					report_mismatch("sold", 32'(oldest.sold), 32'(sold));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_first_samples();
		send_sample(6'd0, 32'h0000_0000);
		send_sample(6'd0, 32'h0000_0000);
		send_sample(6'd63, 32'hFFFF_FFFF);
		send_sample(6'd1, 32'h0001_0000);
		send_sample(6'd1, ref_level[1]);
	endtask

	task automatic test_flips_and_saturation();
		send_sample(6'd63, 32'h0000_0000);
		send_sample(6'd63, 32'h0000_0000);
		send_sample(6'd63, 32'hFFFF_FFFF);
		send_sample(6'd5, 32'hFFFF_FFFF);
		send_sample(6'd5, ref_level[5] - 32'd1);
		send_sample(6'd5, 32'hFFFF_FFFF);
		send_sample(6'd5, 32'hFFFF_0000);
		send_sample(6'd5, 32'hAAAA_5555);
		send_sample(6'd5, 32'h5555_AAAA);
		send_sample(6'd63, 32'h0000_0001);
	endtask

	task automatic test_config_extremes();
		write_reg(trt_pkg::CFG_START, 16'hFFFF);
		write_reg(trt_pkg::CFG_APPROACH, 16'hFFFF);
		send_sample(6'd10, 32'h1234_5678);
		send_sample(6'd10, 32'h9000_0000);
		send_sample(6'd10, 32'h0000_0000);
		write_reg(CFG_SPARE_LO, 16'hFFFF);
		write_reg(CFG_SPARE_HI, 16'h0000);
		send_sample(6'd10, 32'h0000_0001);
		write_reg(trt_pkg::CFG_START, 16'h0000);
		write_reg(trt_pkg::CFG_APPROACH, 16'h0000);
		send_sample(6'd11, 32'hFFFF_FFFF);
		send_sample(6'd11, 32'hFFFF_FFFF);
		send_sample(6'd11, 32'h7FFF_FFFF);
	endtask

	task automatic test_random_phases();
		trt_pkg::chan_t  hot [4];
		trt_pkg::frac_t  st_val;
		trt_pkg::frac_t  ap_val;
		trt_pkg::chan_t  ch;
		trt_pkg::price_t p;
		logic [63:0]     lv;
		logic [63:0]     st;
		int              s;
		int              sel;
		int              sh;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					st_val = trt_pkg::START_RESET;
					ap_val = trt_pkg::APPROACH_RESET;
				end
				1: begin
					st_val = '0;
					ap_val = '0;
				end
				2: begin
					st_val = '1;
					ap_val = '1;
				end
				3: begin
					st_val = trt_pkg::frac_t'(1);
					ap_val = '1;
				end
				4: begin
					st_val = trt_pkg::frac_t'($urandom);
					ap_val = trt_pkg::frac_t'($urandom);
				end
				default: begin
					st_val = trt_pkg::frac_t'($urandom_range(0, 4000));
					ap_val = trt_pkg::frac_t'($urandom_range(0, 8000));
				end
			endcase
			write_reg(trt_pkg::CFG_START, st_val);
			write_reg(trt_pkg::CFG_APPROACH, ap_val);
			foreach (hot[i]) hot[i] = trt_pkg::chan_t'($urandom);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 50 == 0) begin
					tx_idle = ($urandom_range(0, 3) != 0);
					rx_idle = ($urandom_range(0, 3) != 0);
				end
				ch = ($urandom_range(0, 2) == 0) ? trt_pkg::chan_t'($urandom)
					: hot[$urandom_range(0, 3)];
				s = int'(ch) % trt_pkg::CHANNELS;
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					p = $urandom;
				end else if (sel == 1) begin
					p = $urandom_range(0, 1) ? '1 : '0;
				end else begin
					lv = seen_flag[s] ? 64'(ref_level[s]) : 64'($urandom);
					sh = $urandom_range(0, 24);
					st = 64'($urandom) & ((64'd1 << sh) - 64'd1);
					if ($urandom_range(0, 1))
						lv = (lv + st > LEVEL_MAX) ? LEVEL_MAX : lv + st;
					else
						lv = (st > lv) ? 64'd0 : lv - st;
					p = trt_pkg::price_t'(lv);
				end
				send_sample(ch, p);
			end
		end
		tx_idle = 1'b0;
		rx_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_idle();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_results = 1'b1;
		repeat (PRESSURE_ITEMS)
			send_sample(trt_pkg::chan_t'($urandom), trt_pkg::price_t'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_samples();
		test_flips_and_saturation();
		test_config_extremes();
		test_random_phases();
		test_backpressure();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("tb: %0d samples sent, %0d results checked, %0d register writes",
			samples_sent, results_seen, reg_writes);
		$display("tb: %0d first samples, %0d sold/holding flips, %0d stalled input cycles",
			first_samples, flips, input_stalls);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
